// ----- hdl/ple_pkg.sv -----
`default_nettype none

package ple_pkg;

   // Store depth used when the top level is not overridden
   localparam int CAPACITY_DEFAULT = 64;

   // Fixed field widths of the item channels
   localparam int MODE_W   = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 7;

   // Operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POS  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RD_CAP,
      ST_RM_CAP,
      ST_UP,
      ST_UP_FLUSH,
      ST_PUT,
      ST_DN,
      ST_DN_FLUSH,
      ST_FINISH
   } state_type;

   // Store access requested from the datapath in one cycle
   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_WR_LEN,
      MEM_WR_POS,
      MEM_RD_POS,
      MEM_UP,
      MEM_DN,
      MEM_FLUSH
   } mem_op_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic                load;
      mem_op_type          mem_op;
      logic                cur_from_len;
      logic                cur_from_pos;
      logic                len_inc;
      logic                len_dec;
      logic                len_clr;
      logic                cap;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                rsp_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              pos_gt_len;
      logic              pos_ge_len;
      logic              full;
      logic              len_eq_pos;
      logic              up_last;
      logic              dn_last;
      logic              rm_tail;
      logic              rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- hdl/ple_req_if.sv -----
`default_nettype none

interface ple_req_if;
   logic                         valid;
   logic                         ready;
   logic [ple_pkg::MODE_W-1:0]   mode;
   logic [ple_pkg::POS_W-1:0]    position;
   logic [ple_pkg::DATA_W-1:0]   item_data;

   modport source (output valid, output mode, output position, output item_data,
                   input ready);
   modport sink (input valid, input mode, input position, input item_data,
                 output ready);
endinterface

`default_nettype wire

// ----- hdl/ple_rsp_if.sv -----
`default_nettype none

interface ple_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ple_pkg::DATA_W-1:0]    data_out;
   logic [ple_pkg::STATUS_W-1:0]  status;
   logic [ple_pkg::LENGTH_W-1:0]  length;

   modport source (output valid, output data_out, output status, output length,
                   input ready);
   modport sink (input valid, input data_out, input status, input length,
                 output ready);
endinterface

`default_nettype wire

// ----- hdl/ple_ctrl.sv -----
`default_nettype none

module ple_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  ple_pkg::sts_type  sts,
   output ple_pkg::cmd_type  cmd
);

   ple_pkg::state_type state_ff;
   ple_pkg::state_type state_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Select next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (req_valid) state_in = ple_pkg::ST_EVAL;
         end
         ple_pkg::ST_EVAL: begin
            case (sts.mode)
               ple_pkg::MODE_INSERT: begin
                  if (sts.pos_gt_len || sts.full) state_in = ple_pkg::ST_FINISH;
                  else if (sts.len_eq_pos) state_in = ple_pkg::ST_PUT;
                  else state_in = ple_pkg::ST_UP;
               end
               ple_pkg::MODE_REMOVE: begin
                  state_in = sts.pos_ge_len ? ple_pkg::ST_FINISH : ple_pkg::ST_RM_CAP;
               end
               ple_pkg::MODE_READ: begin
                  state_in = sts.pos_ge_len ? ple_pkg::ST_FINISH : ple_pkg::ST_RD_CAP;
               end
               default: state_in = ple_pkg::ST_FINISH;
            endcase
         end
         ple_pkg::ST_RD_CAP:   state_in = ple_pkg::ST_FINISH;
         ple_pkg::ST_RM_CAP: begin
            state_in = sts.rm_tail ? ple_pkg::ST_FINISH : ple_pkg::ST_DN;
         end
         ple_pkg::ST_UP: begin
            if (sts.up_last) state_in = ple_pkg::ST_UP_FLUSH;
         end
         ple_pkg::ST_UP_FLUSH: state_in = ple_pkg::ST_PUT;
         ple_pkg::ST_PUT:      state_in = ple_pkg::ST_FINISH;
         ple_pkg::ST_DN: begin
            if (sts.dn_last) state_in = ple_pkg::ST_DN_FLUSH;
         end
         ple_pkg::ST_DN_FLUSH: state_in = ple_pkg::ST_FINISH;
         ple_pkg::ST_FINISH: begin
            if (sts.rsp_free) state_in = ple_pkg::ST_IDLE;
         end
         default: state_in = ple_pkg::ST_IDLE;
      endcase
   end

   // Drive datapath commands
   always_comb begin
      cmd        = '0;
      cmd.mem_op = ple_pkg::MEM_NONE;
      cmd.status = ple_pkg::STATUS_OK;
      req_ready  = 1'b0;
      case (state_ff)
         ple_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ple_pkg::ST_EVAL: begin
            cmd.set_status = 1'b1;
            case (sts.mode)
               ple_pkg::MODE_APPEND: begin
                  if (sts.full) begin
                     cmd.status = ple_pkg::STATUS_FULL;
                  end else begin
                     cmd.mem_op  = ple_pkg::MEM_WR_LEN;
                     cmd.len_inc = 1'b1;
                  end
               end
               ple_pkg::MODE_INSERT: begin
                  if (sts.pos_gt_len) cmd.status = ple_pkg::STATUS_POS;
                  else if (sts.full) cmd.status = ple_pkg::STATUS_FULL;
                  else if (!sts.len_eq_pos) cmd.cur_from_len = 1'b1;
               end
               ple_pkg::MODE_REMOVE: begin
                  if (sts.pos_ge_len) begin
                     cmd.status = ple_pkg::STATUS_POS;
                  end else begin
                     cmd.mem_op       = ple_pkg::MEM_RD_POS;
                     cmd.cur_from_pos = 1'b1;
                  end
               end
               ple_pkg::MODE_READ: begin
                  if (sts.pos_ge_len) cmd.status = ple_pkg::STATUS_POS;
                  else cmd.mem_op = ple_pkg::MEM_RD_POS;
               end
               ple_pkg::MODE_CLEAR: cmd.len_clr = 1'b1;
               default: ;
            endcase
         end
         ple_pkg::ST_RD_CAP: cmd.cap = 1'b1;
         ple_pkg::ST_RM_CAP: begin
            cmd.cap     = 1'b1;
            cmd.len_dec = sts.rm_tail;
         end
         ple_pkg::ST_UP:       cmd.mem_op = ple_pkg::MEM_UP;
         ple_pkg::ST_UP_FLUSH: cmd.mem_op = ple_pkg::MEM_FLUSH;
         ple_pkg::ST_PUT: begin
            cmd.mem_op  = ple_pkg::MEM_WR_POS;
            cmd.len_inc = 1'b1;
         end
         ple_pkg::ST_DN:       cmd.mem_op = ple_pkg::MEM_DN;
         ple_pkg::ST_DN_FLUSH: begin
            cmd.mem_op  = ple_pkg::MEM_FLUSH;
            cmd.len_dec = 1'b1;
         end
         ple_pkg::ST_FINISH:   cmd.rsp_load = sts.rsp_free;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   // An item is taken only from the idle state
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == ple_pkg::ST_IDLE))
      else $error("item taken outside idle");

   // A taken item always moves to evaluation
   a_load_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ple_pkg::ST_EVAL))
      else $error("evaluation skipped");

   // A loaded result returns the controller to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (state_ff == ple_pkg::ST_IDLE))
      else $error("result loaded without returning to idle");
`endif

endmodule

`default_nettype wire

// ----- hdl/ple_datapath.sv -----
`default_nettype none

module ple_datapath #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  ple_pkg::cmd_type                   cmd,
   output ple_pkg::sts_type                   sts,
   input  wire [ple_pkg::MODE_W-1:0]          req_mode,
   input  wire [ple_pkg::POS_W-1:0]           req_position,
   input  wire [ple_pkg::DATA_W-1:0]          req_item_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [ple_pkg::DATA_W-1:0]         rsp_data_out,
   output logic [ple_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ple_pkg::LENGTH_W-1:0]       rsp_length
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W;

   // Latched request fields
   logic [ple_pkg::MODE_W-1:0]   mode_ff,  mode_in;
   logic [ple_pkg::POS_W-1:0]    pos_ff,   pos_in;
   logic [ple_pkg::DATA_W-1:0]   word_ff,  word_in;

   // List control
   logic [LW-1:0]                len_ff,   len_in;
   logic [AW-1:0]                cur_ff,   cur_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [AW-1:0]                pend_addr_ff,  pend_addr_in;

   // Result under construction and output register
   logic [ple_pkg::DATA_W-1:0]   res_data_ff,   res_data_in;
   logic [ple_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                         rsp_valid_ff,  rsp_valid_in;
   logic [ple_pkg::DATA_W-1:0]   rsp_data_ff,   rsp_data_in;
   logic [ple_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ple_pkg::LENGTH_W-1:0] rsp_length_ff, rsp_length_in;

   // Store
   logic [ple_pkg::DATA_W-1:0]   store_ff [CAPACITY];
   logic [ple_pkg::DATA_W-1:0]   rd_data_ff;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [ple_pkg::DATA_W-1:0]   wr_data;

   logic [AW-1:0]                pos_addr;
   logic [CW-1:0]                pos_x;
   logic [CW-1:0]                len_x;

   assign pos_addr = AW'(pos_ff);
   assign pos_x    = CW'(pos_ff);
   assign len_x    = CW'(len_ff);

   // Decode store access; a shift step reads one entry and writes the previous read
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = pos_addr;
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      case (cmd.mem_op)
         ple_pkg::MEM_WR_LEN: begin
            wr_en   = 1'b1;
            wr_addr = len_ff[AW-1:0];
            wr_data = word_ff;
         end
         ple_pkg::MEM_WR_POS: begin
            wr_en   = 1'b1;
            wr_addr = pos_addr;
            wr_data = word_ff;
         end
         ple_pkg::MEM_RD_POS: begin
            rd_en = 1'b1;
         end
         ple_pkg::MEM_UP: begin
            rd_en         = 1'b1;
            rd_addr       = cur_ff - AW'(1);
            wr_en         = pend_valid_ff;
            pend_valid_in = 1'b1;
            pend_addr_in  = cur_ff;
         end
         ple_pkg::MEM_DN: begin
            rd_en         = 1'b1;
            rd_addr       = cur_ff + AW'(1);
            wr_en         = pend_valid_ff;
            pend_valid_in = 1'b1;
            pend_addr_in  = cur_ff;
         end
         ple_pkg::MEM_FLUSH: begin
            wr_en         = pend_valid_ff;
            pend_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Write and read the store
   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= store_ff[rd_addr];
   end

   // Update list control and result
   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      len_in        = len_ff;
      cur_in        = cur_ff;

      if (cmd.load) begin
         mode_in     = req_mode;
         pos_in      = req_position;
         word_in     = req_item_data;
         res_data_in = '0;
      end
      if (cmd.cap) res_data_in = rd_data_ff;
      if (cmd.set_status) res_status_in = cmd.status;

      if (cmd.len_clr) len_in = '0;
      else if (cmd.len_inc) len_in = len_ff + LW'(1);
      else if (cmd.len_dec) len_in = len_ff - LW'(1);

      if (cmd.cur_from_len) cur_in = len_ff[AW-1:0];
      else if (cmd.cur_from_pos) cur_in = pos_addr;
      else if (cmd.mem_op == ple_pkg::MEM_UP) cur_in = cur_ff - AW'(1);
      else if (cmd.mem_op == ple_pkg::MEM_DN) cur_in = cur_ff + AW'(1);
   end

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = res_data_ff;
         rsp_status_in = res_status_ff;
         rsp_length_in = ple_pkg::LENGTH_W'(len_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      cur_ff        <= cur_in;
      pend_addr_ff  <= pend_addr_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Report conditions to the controller
   always_comb begin
      sts.mode       = mode_ff;
      sts.pos_gt_len = pos_x > len_x;
      sts.pos_ge_len = pos_x >= len_x;
      sts.len_eq_pos = pos_x == len_x;
      sts.full       = len_ff == LW'(CAPACITY);
      sts.up_last    = (cur_ff - AW'(1)) == pos_addr;
      sts.dn_last    = (CW'(cur_ff) + CW'(2)) == len_x;
      sts.rm_tail    = (pos_x + CW'(1)) == len_x;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_length   = rsp_length_ff;

`ifndef SYNTHESIS
   // Length never passes the store depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      int'(len_ff) <= CAPACITY)
      else $error("list length beyond capacity");

   // Every write lands inside the store
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (int'(wr_addr) < CAPACITY))
      else $error("store write out of range");

   // The new word goes in only after the shift write is flushed
   a_put_flushed: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_op == ple_pkg::MEM_WR_POS) |-> !pend_valid_ff)
      else $error("insert write with shift still pending");

   // A result is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   // Results carry only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == ple_pkg::STATUS_OK
                        || rsp_status_ff == ple_pkg::STATUS_POS
                        || rsp_status_ff == ple_pkg::STATUS_FULL))
      else $error("undefined status code");
`endif

endmodule

`default_nettype wire

// ----- hdl/positional_list_engine_core.sv -----
// Positional list engine: an ordered list of 32-bit words kept packed in a
// store of CAPACITY entries, list position p sitting in entry p.
// Request channel (req_ch): mode, position, item_data; an item is taken on
// a clock edge with valid and ready high. Ready is high only while the
// engine is idle, so one item is in work at a time.
// Result channel (rsp_ch): data_out, status, length; exactly one result per
// item, in order, held in an output register until taken.
// Append, clear and errors go straight to the result; read, remove at the
// tail and insert at the end make one store access first; any other
// remove or insert first shifts the entries between the position and
// the tail. The shift moves one entry per cycle through the single store
// read port and write port. The next item can be taken from the cycle
// after its predecessor's result is loaded.
// A stalled receiver holds the result register; the engine still takes and
// works the next item and waits at its end until the register is free.
// Reset (synchronous, active high) empties the list and drops any pending
// result; the store contents are not cleared.
`default_nettype none

module positional_list_engine_core #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   ple_req_if.sink    req_ch,
   ple_rsp_if.source  rsp_ch
);

   ple_pkg::cmd_type cmd;
   ple_pkg::sts_type sts;
   logic             req_ready;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_mode      (req_ch.mode),
      .req_position  (req_ch.position),
      .req_item_data (req_ch.item_data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_data_out  (rsp_ch.data_out),
      .rsp_status    (rsp_ch.status),
      .rsp_length    (rsp_ch.length)
   );

   assign req_ch.ready = req_ready;

endmodule

`default_nettype wire
